// File: src/bda_pkg.sv
// Package for the binary to decimal ASCII converter: widths, constants, types.
package bda_pkg;

  localparam int unsigned ValueW    = 32;
  localparam int unsigned CharW     = 6;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned BcdW      = NumDigits * DigitW;
  localparam int unsigned BitCntW   = $clog2(ValueW);
  localparam int unsigned DigCntW   = $clog2(NumDigits);

  localparam logic [CharW-1:0]   AsciiZero = CharW'(48);
  localparam logic [DigitW-1:0]  DabbleMin = DigitW'(5);
  localparam logic [DigitW-1:0]  DabbleAdd = DigitW'(3);
  localparam logic [BitCntW-1:0] LastBit   = BitCntW'(ValueW - 1);
  localparam logic [DigCntW-1:0] LastDigit = DigCntW'(NumDigits - 1);

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StConv = 4'b0010,
    StSkip = 4'b0100,
    StEmit = 4'b1000
  } state_e;

  typedef logic [BcdW-1:0] bcd_t;

  // One double-dabble correction: add 3 to every digit of 5 or more
  function automatic bcd_t dabble_adjust(input bcd_t bcd);
    bcd_t res;
    res = bcd;
    for (int unsigned i = 0; i < NumDigits; i++) begin
      if (bcd[i*DigitW +: DigitW] >= DabbleMin) begin
        res[i*DigitW +: DigitW] = bcd[i*DigitW +: DigitW] + DabbleAdd;
      end
    end
    return res;
  endfunction

endpackage

// File: src/binary_to_decimal_ascii.sv
// Top level: converts an unsigned 32-bit value to decimal ASCII digits, MSD first.
// Each transaction passes through accept in idle, one shift-add-3 step per input bit on
// the double-dabble unit, a skip state that drops leading zeros and then starts output,
// then an emit state that outputs the digits in order and holds while the output stalls.
// The input is stalled for the whole conversion; one value at a time.
// Asynchronous active-low reset returns the sequencer to idle, no output valid.
module binary_to_decimal_ascii
  import bda_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [ValueW-1:0] value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CharW-1:0]  digit_char_o,
  output logic              last_o
);

  state_e              state_q, state_d;
  logic [BitCntW-1:0]  bit_cnt_q, bit_cnt_d;
  logic [DigCntW-1:0]  dig_cnt_q, dig_cnt_d;
  logic [ValueW-1:0]   bin_q, bin_d;
  bcd_t                bcd_q, bcd_d;
  bcd_t                bcd_adj;
  logic [DigitW-1:0]   top_digit;

  assign bcd_adj   = dabble_adjust(bcd_q);
  assign top_digit = bcd_q[BcdW-1 -: DigitW];

  // Sequencer
  always_comb begin
    state_d   = state_q;
    bit_cnt_d = bit_cnt_q;
    dig_cnt_d = dig_cnt_q;
    bin_d     = bin_q;
    bcd_d     = bcd_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          bin_d     = value_i;
          bcd_d     = '0;
          bit_cnt_d = '0;
          state_d   = StConv;
        end
      end
      StConv: begin
        // adjust, then shift one binary bit into the BCD word
        {bcd_d, bin_d} = {bcd_adj, bin_q} << 1;
        bit_cnt_d      = bit_cnt_q + 1'b1;
        if (bit_cnt_q == LastBit) begin
          dig_cnt_d = '0;
          state_d   = StSkip;
        end
      end
      StSkip: begin
        // drop leading zeros, always keep the final digit
        if (top_digit == '0 && dig_cnt_q != LastDigit) begin
          bcd_d     = bcd_q << DigitW;
          dig_cnt_d = dig_cnt_q + 1'b1;
        end else begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (!out_stall_i) begin
          if (dig_cnt_q == LastDigit) begin
            state_d = StIdle;
          end else begin
            bcd_d     = bcd_q << DigitW;
            dig_cnt_d = dig_cnt_q + 1'b1;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      bit_cnt_q <= '0;
      dig_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      bit_cnt_q <= bit_cnt_d;
      dig_cnt_q <= dig_cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign in_stall_o   = (state_q != StIdle);
  assign out_valid_o  = (state_q == StEmit);
  assign digit_char_o = AsciiZero + CharW'(top_digit);
  assign last_o       = (dig_cnt_q == LastDigit);

endmodule
